[src/cdh_pkg.sv]
// Shared types, constants and helpers for the coverage depth histogram.
// Used by cdh_ctrl, cdh_dp and coverage_depth_histogram; depends on nothing.
package cdh_pkg;

   // ring size must be a power of two: a position's slot is its low bits
   localparam int CDH_RING_SIZE = 1024;
   localparam int CDH_HIST_BINS = 256;

   // Item kinds carried in the request tuser
   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_OP    = 2'd1;
   localparam logic [1:0] FUNC_FLUSH = 2'd2;
   localparam logic [1:0] FUNC_BIN   = 2'd3;

   // Register map, word index
   localparam logic REG_DEPTH_CAP = 1'b0;

   // Match, sequence equal and sequence mismatch raise coverage
   localparam logic [15:0] COVERING_OPS = 16'b0000_0001_1000_0001;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_CAPTURE,
      OP_RET_SETUP,
      OP_RING_RD,
      OP_RET_BIN,
      OP_RET_WR,
      OP_EXC_RD,
      OP_EXC_WR,
      OP_COMMIT,
      OP_COV_SETUP,
      OP_COV_WR,
      OP_HIST_RD,
      OP_OUT_LOAD
   } cdh_op_type;

   typedef struct packed {
      cdh_op_type op;
   } cdh_cmd_type;

   typedef struct packed {
      logic       clear_done;
      logic [1:0] func;
      logic       start_retire;
      logic       flush_retire;
      logic       remain_zero;
      logic       out_free;
   } cdh_status_type;

   function automatic logic cdh_covering(input logic [3:0] code);
      return COVERING_OPS[code];
   endfunction

endpackage

[src/cdh_ctrl.sv]
// Sequencer for the coverage depth histogram: steps the datapath through
// each item's ring walk. Depends on cdh_pkg.
module cdh_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  cdh_pkg::cdh_status_type stat,
   output cdh_pkg::cdh_cmd_type    cmd
);
   import cdh_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_RET_SETUP,
      S_RET_RD,
      S_RET_BIN,
      S_RET_WR,
      S_EXC_RD,
      S_EXC_WR,
      S_COMMIT,
      S_COV_SETUP,
      S_COV_RD,
      S_COV_WR,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;
   logic      hist_pending_ff, hist_pending_in;

   always_comb begin
      state_in        = state_ff;
      hist_pending_in = 1'b0;
      cmd.op          = OP_NONE;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (stat.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_CAPTURE;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.func)
               FUNC_START: state_in = stat.start_retire ? S_RET_SETUP : S_COMMIT;
               FUNC_FLUSH: state_in = stat.flush_retire ? S_RET_SETUP : S_COMMIT;
               FUNC_OP:    state_in = S_COV_SETUP;
               default: begin
                  cmd.op          = OP_HIST_RD;
                  hist_pending_in = 1'b1;
                  state_in        = S_FINISH;
               end
            endcase
         end
         S_RET_SETUP: begin
            cmd.op   = OP_RET_SETUP;
            state_in = S_RET_RD;
         end
         S_RET_RD: begin
            cmd.op   = OP_RING_RD;
            state_in = S_RET_BIN;
         end
         S_RET_BIN: begin
            cmd.op   = OP_RET_BIN;
            state_in = S_RET_WR;
         end
         S_RET_WR: begin
            cmd.op   = OP_RET_WR;
            state_in = stat.remain_zero ? S_EXC_RD : S_RET_RD;
         end
         S_EXC_RD: begin
            cmd.op   = OP_EXC_RD;
            state_in = S_EXC_WR;
         end
         S_EXC_WR: begin
            cmd.op   = OP_EXC_WR;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.op   = OP_COMMIT;
            state_in = S_FINISH;
         end
         S_COV_SETUP: begin
            cmd.op   = OP_COV_SETUP;
            state_in = S_COV_RD;
         end
         S_COV_RD: begin
            if (stat.remain_zero) begin
               state_in = S_FINISH;
            end else begin
               cmd.op   = OP_RING_RD;
               state_in = S_COV_WR;
            end
         end
         S_COV_WR: begin
            cmd.op   = OP_COV_WR;
            state_in = S_COV_RD;
         end
         S_FINISH: begin
            // hold until the output register is free
            if (stat.out_free) begin
               cmd.op   = OP_OUT_LOAD;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         ready_ff        <= 1'b0;
         hist_pending_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         ready_ff        <= (state_in == S_IDLE);
         hist_pending_ff <= hist_pending_in;
      end
   end

   assign req_tready = ready_ff & ~hist_pending_ff;

endmodule

[src/cdh_dp.sv]
// Datapath of the coverage depth histogram: coverage ring and bin memories,
// window registers and walk counters. Depends on cdh_pkg.
module cdh_dp #(
   parameter int RING_SIZE = cdh_pkg::CDH_RING_SIZE,
   parameter int HIST_BINS = cdh_pkg::CDH_HIST_BINS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cdh_pkg::cdh_cmd_type    cmd,
   output cdh_pkg::cdh_status_type stat,
   input  logic [1:0]              req_func,
   input  logic [30:0]             req_read_start,
   input  logic [30:0]             req_read_end,
   input  logic [3:0]              req_op_code,
   input  logic [27:0]             req_op_length,
   input  logic [7:0]              req_bin_index,
   input  logic [7:0]              depth_cap,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic                    rsp_status,
   output logic [31:0]             rsp_bin_count,
   output logic [30:0]             rsp_window_start
);
   import cdh_pkg::*;

   localparam int RW    = $clog2(RING_SIZE);
   localparam int CW    = $clog2(RING_SIZE + 1);
   localparam int BW    = $clog2(HIST_BINS);
   localparam int CLR_N = (RING_SIZE > HIST_BINS) ? RING_SIZE : HIST_BINS;
   localparam int CLW   = $clog2(CLR_N);

   logic [15:0] ring_mem [RING_SIZE];
   logic [31:0] bin_mem  [HIST_BINS];

   // captured item
   logic [1:0]  func_ff;
   logic [30:0] rstart_ff, rend_ff;
   logic [3:0]  code_ff;
   logic [27:0] len_ff;
   logic [7:0]  bidx_ff;

   // window state
   logic [30:0]        wb_ff;
   logic signed [31:0] wl_ff;
   logic [RW-1:0]      base_ff;
   logic [CW-1:0]      cursor_ff;

   // walk state
   logic [RW-1:0]  ptr_ff;
   logic [CW-1:0]  remain_ff;
   logic [31:0]    excess_ff;
   logic [15:0]    ring_rdata_ff;
   logic [31:0]    bin_rdata_ff;
   logic [BW-1:0]  bin_idx_ff;
   logic           status_ff;
   logic [CLW-1:0] clr_ff;

   logic           out_valid_ff, out_status_ff;
   logic [31:0]    out_count_ff;
   logic [30:0]    out_wstart_ff;

   // combinational helpers
   logic [RW-1:0] ptr_next;
   logic [7:0]    depth_capped;
   logic [BW-1:0] depth_bin;
   logic [31:0]   ret_count, ret_n;
   logic [28:0]   stop;
   logic [28:0]   lim;
   logic          covering;
   logic [RW:0]   psum;
   logic [32:0]   bin_sum_one, bin_sum_exc;
   logic          bidx_ok;

   logic          ring_we;
   logic [RW-1:0] ring_waddr;
   logic [15:0]   ring_wdata;
   logic          bin_we, bin_re;
   logic [BW-1:0] bin_waddr, bin_raddr;
   logic [31:0]   bin_wdata;

   always_comb begin
      ptr_next = (ptr_ff == RW'(RING_SIZE - 1)) ? '0 : ptr_ff + RW'(1);

      depth_capped = (ring_rdata_ff > 16'(depth_cap)) ? depth_cap : ring_rdata_ff[7:0];
      if (32'(depth_capped) > 32'(HIST_BINS - 1)) depth_bin = BW'(HIST_BINS - 1);
      else                                         depth_bin = BW'(depth_capped);

      if (func_ff == FUNC_START) ret_count = {1'b0, rstart_ff - wb_ff};
      else                       ret_count = 32'(wl_ff - $signed({1'b0, wb_ff}));
      ret_n = (ret_count < 32'(RING_SIZE)) ? ret_count : 32'(RING_SIZE);

      stop     = 29'(cursor_ff) + 29'(len_ff);
      lim      = (stop < 29'(RING_SIZE)) ? stop : 29'(RING_SIZE);
      covering = cdh_covering(code_ff);
      psum     = (RW+1)'(base_ff) + (RW+1)'(cursor_ff);

      bin_sum_one = 33'(bin_rdata_ff) + 33'd1;
      bin_sum_exc = 33'(bin_rdata_ff) + 33'(excess_ff);
      bidx_ok     = 32'(bidx_ff) < 32'(HIST_BINS);
   end

   // memory ports
   always_comb begin
      ring_we    = 1'b0;
      ring_waddr = ptr_ff;
      ring_wdata = '0;
      bin_we     = 1'b0;
      bin_waddr  = bin_idx_ff;
      bin_wdata  = bin_sum_one[32] ? 32'hFFFF_FFFF : bin_sum_one[31:0];
      bin_re     = 1'b0;
      bin_raddr  = depth_bin;
      unique case (cmd.op)
         OP_CLEAR: begin
            ring_we    = 32'(clr_ff) < 32'(RING_SIZE);
            ring_waddr = clr_ff[RW-1:0];
            bin_we     = 32'(clr_ff) < 32'(HIST_BINS);
            bin_waddr  = clr_ff[BW-1:0];
            bin_wdata  = '0;
         end
         OP_RET_BIN: begin
            ring_we = 1'b1;
            bin_re  = 1'b1;
         end
         OP_RET_WR: bin_we = 1'b1;
         OP_EXC_RD: begin
            bin_re    = 1'b1;
            bin_raddr = '0;
         end
         OP_EXC_WR: begin
            bin_we    = 1'b1;
            bin_waddr = '0;
            bin_wdata = bin_sum_exc[32] ? 32'hFFFF_FFFF : bin_sum_exc[31:0];
         end
         OP_COV_WR: begin
            ring_we    = 1'b1;
            ring_wdata = (ring_rdata_ff == 16'hFFFF) ? ring_rdata_ff
                                                     : ring_rdata_ff + 16'd1;
         end
         OP_HIST_RD: begin
            bin_re    = 1'b1;
            bin_raddr = BW'(bidx_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ring_we) ring_mem[ring_waddr] <= ring_wdata;
      if (cmd.op == OP_RING_RD) ring_rdata_ff <= ring_mem[ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (bin_we) bin_mem[bin_waddr] <= bin_wdata;
      if (bin_re) bin_rdata_ff <= bin_mem[bin_raddr];
   end

   // payload registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_CAPTURE: begin
            func_ff   <= req_func;
            rstart_ff <= req_read_start;
            rend_ff   <= req_read_end;
            code_ff   <= req_op_code;
            len_ff    <= req_op_length;
            bidx_ff   <= req_bin_index;
            status_ff <= 1'b0;
         end
         OP_RET_SETUP: begin
            ptr_ff    <= base_ff;
            remain_ff <= CW'(ret_n);
            excess_ff <= ret_count - ret_n;
         end
         OP_RET_BIN: begin
            bin_idx_ff <= depth_bin;
            ptr_ff     <= ptr_next;
            remain_ff  <= remain_ff - CW'(1);
         end
         OP_COV_SETUP: begin
            ptr_ff    <= (psum >= (RW+1)'(RING_SIZE)) ? RW'(psum - (RW+1)'(RING_SIZE))
                                                      : RW'(psum);
            remain_ff <= (covering && lim > 29'(cursor_ff)) ? CW'(lim - 29'(cursor_ff))
                                                           : '0;
            status_ff <= covering && (stop > 29'(RING_SIZE));
         end
         OP_COV_WR: begin
            ptr_ff    <= ptr_next;
            remain_ff <= remain_ff - CW'(1);
         end
         default: ;
      endcase
   end

   // window and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wb_ff        <= '0;
         wl_ff        <= -32'sd1;
         base_ff      <= '0;
         cursor_ff    <= '0;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == OP_CLEAR) clr_ff <= clr_ff + CLW'(1);
         if (cmd.op == OP_COMMIT) begin
            if (func_ff == FUNC_START) begin
               if (rstart_ff > wb_ff) begin
                  wb_ff   <= rstart_ff;
                  base_ff <= rstart_ff[RW-1:0];
               end
               if ($signed({1'b0, rend_ff}) > wl_ff) wl_ff <= $signed({1'b0, rend_ff});
            end else begin
               wb_ff   <= '0;
               base_ff <= '0;
               wl_ff   <= -32'sd1;
            end
            cursor_ff <= '0;
         end
         if (cmd.op == OP_COV_SETUP)
            cursor_ff <= (stop > 29'(RING_SIZE)) ? CW'(RING_SIZE) : CW'(stop);
         if (cmd.op == OP_OUT_LOAD) out_valid_ff <= 1'b1;
         else if (rsp_ready)        out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_OUT_LOAD) begin
         out_status_ff <= status_ff;
         out_count_ff  <= (func_ff == FUNC_BIN && bidx_ok) ? bin_rdata_ff : '0;
         out_wstart_ff <= wb_ff;
      end
   end

   always_comb begin
      stat.clear_done   = (clr_ff == CLW'(CLR_N - 1));
      stat.func         = func_ff;
      stat.start_retire = rstart_ff > wb_ff;
      stat.flush_retire = wl_ff > $signed({1'b0, wb_ff});
      stat.remain_zero  = (remain_ff == '0);
      stat.out_free     = ~out_valid_ff | rsp_ready;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_bin_count    = out_count_ff;
   assign rsp_window_start = out_wstart_ff;

endmodule

[src/coverage_depth_histogram.sv]
// Top level of the coverage depth histogram: stream ports, register port,
// sequencer and datapath. Depends on cdh_pkg, cdh_ctrl and cdh_dp.
//
// Reads arrive as a read-start word followed by its alignment-operation words;
// every accepted word yields one response word. One word is worked on at a
// time. After reset a clearing pass empties the coverage ring and the bins
// before the first word is taken. For a read start that retires positions,
// each walked position is a ring read, a bin read and a bin write. The new
// window slot is taken from the low bits of the read start, so RING_SIZE must
// be a power of two. Each position that a covering operation covers is a ring
// read and a ring write. A flush retires positions as a read start does.
// depth_cap is register 0 at byte address 0.
module coverage_depth_histogram #(
   parameter int RING_SIZE = cdh_pkg::CDH_RING_SIZE,
   parameter int HIST_BINS = cdh_pkg::CDH_HIST_BINS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,  // read_start, read_end, op_code, op_length, bin_index
   input  logic [1:0]   req_tuser,  // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,  // bin_count, window_start
   output logic [0:0]   rsp_tuser,  // status
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import cdh_pkg::*;

   cdh_cmd_type    cmd;
   cdh_status_type stat;
   logic [7:0]     depth_cap_ff;
   logic           rsp_status;
   logic [31:0]    rsp_bin_count;
   logic [30:0]    rsp_window_start;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_cap_ff <= 8'd255;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == REG_DEPTH_CAP) begin
         depth_cap_ff <= csr_pwdata[7:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_DEPTH_CAP) ? {24'd0, depth_cap_ff} : 32'd0;

   cdh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   cdh_dp #(
      .RING_SIZE (RING_SIZE),
      .HIST_BINS (HIST_BINS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_func         (req_tuser),
      .req_read_start   (req_tdata[30:0]),
      .req_read_end     (req_tdata[61:31]),
      .req_op_code      (req_tdata[65:62]),
      .req_op_length    (req_tdata[93:66]),
      .req_bin_index    (req_tdata[101:94]),
      .depth_cap        (depth_cap_ff),
      .rsp_ready        (rsp_tready),
      .rsp_valid        (rsp_tvalid),
      .rsp_status       (rsp_status),
      .rsp_bin_count    (rsp_bin_count),
      .rsp_window_start (rsp_window_start)
   );

   assign rsp_tdata = {1'b0, rsp_window_start, rsp_bin_count};
   assign rsp_tuser = rsp_status;

`ifndef NO_ASSERTIONS
   a_one_word_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("word accepted while the previous one is still in work");

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_CLEAR |-> !req_tready)
      else $error("input ready during the clearing pass");

   a_truncation_has_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[31:0] == 32'd0)
      else $error("truncated operation reports a bin count");
`endif

endmodule

[sim/cdh_checker.sv]
// Checker for the coverage depth histogram: watches the request, response and
// register ports, predicts every response word and compares it field by field.
// Depends on cdh_pkg.
`timescale 1ns / 1ps

module cdh_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [103:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [63:0]  rsp_tdata,
   input  logic [0:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic         csr_pready,
   output int           fail_count,
   output int           words_pending
);
   import cdh_pkg::*;

   localparam int RING = CDH_RING_SIZE;
   localparam int BINS = CDH_HIST_BINS;

   typedef struct packed {
      logic        status;
      logic [31:0] bin_count;
      logic [30:0] window_start;
   } answer_type;

   logic [15:0]    depth_at [RING];
   logic [31:0]    bin_tally [BINS];
   logic [30:0]    win_begin;
   longint         win_last;
   int unsigned    cursor;
   logic [7:0]     cap;
   answer_type     answers_due [$];

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic void tally_bin(input int unsigned idx, input longint unsigned amount);
      longint unsigned sum;
      if (idx >= BINS) idx = BINS - 1;
      sum = longint'(bin_tally[idx]) + amount;
      bin_tally[idx] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   // Count positions from the window start into the histogram; beyond the ring they are zero.
   function automatic void retire_span(input longint unsigned span);
      longint unsigned n;
      int unsigned slot, d;
      n = (span < RING) ? span : RING;
      for (longint unsigned k = 0; k < n; k++) begin
         slot = 32'((longint'(win_begin) + k) % RING);
         d = depth_at[slot];
         if (d > cap) d = cap;
         tally_bin(d, 1);
         depth_at[slot] = '0;
      end
      if (span > n) tally_bin(0, span - n);
   endfunction

   function automatic answer_type predict_word(input logic [1:0] kind, input logic [103:0] d);
      answer_type a;
      logic [30:0] rs, re;
      logic [3:0]  code;
      logic [27:0] len;
      logic [7:0]  bidx;
      longint unsigned stop, lim;
      int unsigned slot;
      rs = d[30:0]; re = d[61:31]; code = d[65:62]; len = d[93:66]; bidx = d[101:94];
      a = '0;
      case (kind)
         FUNC_START: begin
            if (rs > win_begin) begin
               retire_span(rs - win_begin);
               win_begin = rs;
            end
            if (longint'(re) > win_last) win_last = re;
            cursor = 0;
         end
         FUNC_OP: begin
            stop = longint'(cursor) + len;
            if (COVERING_OPS[code]) begin
               lim = (stop < RING) ? stop : RING;
               for (longint unsigned i = cursor; i < lim; i++) begin
                  slot = 32'((longint'(win_begin) + i) % RING);
                  if (depth_at[slot] != 16'hFFFF) depth_at[slot]++;
               end
               if (stop > RING) a.status = 1'b1;
            end
            cursor = (stop > RING) ? RING : 32'(stop);
         end
         FUNC_FLUSH: begin
            if (win_last > longint'(win_begin)) retire_span(win_last - longint'(win_begin));
            win_begin = '0;
            win_last = -1;
            cursor = 0;
         end
         default: if (bidx < BINS) a.bin_count = bin_tally[bidx];
      endcase
      a.window_start = win_begin;
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         foreach (depth_at[i]) depth_at[i] = '0;
         foreach (bin_tally[i]) bin_tally[i] = '0;
         win_begin = '0;
         win_last = -1;
         cursor = 0;
         cap = 8'd255;
         answers_due.delete();
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == {REG_DEPTH_CAP, 2'b00})
            cap = csr_pwdata[7:0];
         if (req_tvalid && req_tready) answers_due.push_back(predict_word(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (answers_due.size() == 0) begin
               report_mismatch("unexpected word", rsp_tdata, 0);
            end else begin
               want = answers_due.pop_front();
               if (rsp_tuser[0] !== want.status)
                  report_mismatch("status", rsp_tuser[0], want.status);
               if (rsp_tdata[31:0] !== want.bin_count)
                  report_mismatch("bin_count", rsp_tdata[31:0], want.bin_count);
               if (rsp_tdata[62:32] !== want.window_start)
                  report_mismatch("window_start", rsp_tdata[62:32], want.window_start);
            end
         end
      end
      words_pending = answers_due.size();
   end

endmodule

[sim/tb.sv]
// Testbench top for coverage_depth_histogram: clock, reset, stimulus, register
// writes and verdict. Depends on cdh_pkg, the block and cdh_checker.
`timescale 1ns / 1ps

module tb;
   import cdh_pkg::*;

   localparam int IDLE_LIMIT = 20000;
   localparam int HOLD_CYCLES = 400;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;
   logic [1:0]   req_tuser = FUNC_BIN;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   int fail_count, words_pending;
   int send_idle_pct = 8, recv_idle_pct = 60;
   int hold_asked = 0, hold_taken = 0, hold_left = 0, quiet = 0;
   int unsigned sent = 0;
   int unsigned pos = 0;

   always #5 clock = ~clock;

   coverage_depth_histogram dut (.*);

   cdh_checker u_checker (.*);

   // Response side: random stalls, plus one long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (hold_taken != hold_asked) begin
         hold_taken = hold_asked;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_word(input logic [1:0] kind, input logic [30:0] rs, input logic [30:0] re,
                            input logic [3:0] code, input logic [27:0] len,
                            input logic [7:0] bidx);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {2'b00, bidx, len, code, re, rs};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic write_cap(input logic [7:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {REG_DEPTH_CAP, 2'b00};
      csr_pwdata <= {24'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // One read start followed by its alignment operations, most of them covering
   task automatic send_read();
      int unsigned r, span, nops;
      logic [27:0] len;
      logic [3:0]  code;
      r = $urandom_range(0, 99);
      if (r < 5) pos += $urandom_range(1025, 3000);
      else if (r < 9) pos = (pos > 20) ? pos - $urandom_range(0, 20) : 0;
      else pos += $urandom_range(0, 30);
      span = $urandom_range(20, 150);
      send_word(FUNC_START, 31'(pos), 31'(pos + span - 1), 4'd0, 28'd0, 8'($urandom));
      nops = $urandom_range(1, 4);
      repeat (nops) begin
         r = $urandom_range(0, 99);
         case ($urandom_range(0, 9))
            0, 1, 2:    code = 4'd0;
            3, 4:       code = 4'd7;
            5, 6:       code = 4'd8;
            default:    code = 4'($urandom);
         endcase
         if (r < 3) len = 28'($urandom_range(900, 1200));
         else if (r < 5) len = 28'($urandom);
         else len = 28'($urandom_range(1, span));
         send_word(FUNC_OP, 31'($urandom), 31'($urandom), code, len, 8'($urandom));
      end
   endtask

   task automatic send_mixed(input int unsigned target);
      int unsigned r;
      logic [1:0] kind;
      logic [30:0] rs;
      while (sent < target) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            send_read();
         end else if (r < 85) begin
            send_word(FUNC_BIN, 31'($urandom), 31'($urandom), 4'($urandom), 28'($urandom),
                      8'($urandom));
         end else if (r < 90) begin
            send_word(FUNC_FLUSH, 31'($urandom), 31'($urandom), 4'($urandom), 28'($urandom),
                      8'($urandom));
            pos = $urandom_range(0, 100);
         end else begin
            kind = 2'($urandom);
            rs = 31'($urandom);
            send_word(kind, rs, 31'($urandom), 4'($urandom), 28'($urandom), 8'($urandom));
            if (kind == FUNC_START && 32'(rs) > pos) pos = 32'(rs);
            if (kind == FUNC_FLUSH) pos = 0;
         end
         // keep well clear of the top of the position range
         if (pos > 32'h7FFF_0000) begin
            send_word(FUNC_FLUSH, 0, 0, 0, 0, 0);
            pos = 0;
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty window, cursor saturation, reads before the window,
      // gaps past the ring, flushes and bin-count saturation
      send_word(FUNC_BIN, 0, 0, 0, 0, 8'd0);
      send_word(FUNC_OP, 0, 0, 4'd0, 28'd5, 0);
      send_word(FUNC_OP, 0, 0, 4'd15, 28'hFFF_FFFF, 0);
      send_word(FUNC_OP, 0, 0, 4'd7, 28'd3, 0);
      send_word(FUNC_START, 31'd10, 31'd30, 0, 0, 0);
      send_word(FUNC_OP, 0, 0, 4'd0, 28'd8, 0);
      send_word(FUNC_OP, 0, 0, 4'd8, 28'd4, 0);
      send_word(FUNC_OP, 0, 0, 4'd4, 28'd3, 0);
      send_word(FUNC_OP, 0, 0, 4'd7, 28'd2000, 0);
      send_word(FUNC_START, 31'd5, 31'd20, 0, 0, 0);
      send_word(FUNC_OP, 0, 0, 4'd0, 28'd3, 0);
      send_word(FUNC_START, 31'd2000, 31'd2100, 0, 0, 0);
      send_word(FUNC_BIN, 0, 0, 0, 0, 8'd0);
      send_word(FUNC_BIN, 0, 0, 0, 0, 8'd1);
      send_word(FUNC_BIN, 0, 0, 0, 0, 8'd255);
      send_word(FUNC_FLUSH, 0, 0, 0, 0, 0);
      send_word(FUNC_FLUSH, 0, 0, 0, 0, 0);
      repeat (3) begin
         send_word(FUNC_START, 31'd0, 31'h7FFF_FFFF, 0, 0, 0);
         send_word(FUNC_FLUSH, 0, 0, 0, 0, 0);
      end
      send_word(FUNC_BIN, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 4'hF, 28'hFFF_FFFF, 8'd0);

      write_cap(8'd0);
      send_mixed(sent + 120);
      write_cap(8'd3);
      send_mixed(sent + 150);

      send_idle_pct = 60;
      recv_idle_pct = 8;
      write_cap(8'($urandom));
      send_mixed(sent + 240);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_cap(8'd255);
      send_mixed(sent + 60);
      hold_asked++;
      send_mixed(sent + 180);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
